// ===== rtl/pic_pkg.sv =====
// Shared constants, operation codes and controller/datapath interface types.
package pic_pkg;

   // Default sizing of the point store and coordinates.
   localparam int POINT_CAPACITY_DEF = 256;
   localparam int COORD_BITS_DEF     = 10;

   // Width of the reported count field.
   localparam int COUNT_BITS = 9;

   // Operation codes carried by an input word.
   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_ADD   = 2'd1,
      OP_QUERY = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear;    // empty the store and drop the overflow flag
      logic add;      // append the presented point
      logic start;    // latch a query centre and radius, rewind the scan
      logic issue;    // read the next stored point into the pipeline
      logic publish;  // load the result register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_done;  // every stored point has been issued
      logic pipe_busy;  // points are still moving through the pipeline
   } status_type;

endpackage

// ===== rtl/pic_ctrl.sv =====
// Controller state machine sequencing clear, add and query words.
module pic_ctrl
   import pic_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_op,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output cmd_type    cmd,
   input  status_type status
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   op_type    op;

   assign op        = op_type'(req_op);
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (op)
                  OP_CLEAR: cmd.clear = 1'b1;
                  OP_ADD:   cmd.add   = 1'b1;
                  OP_QUERY: begin
                     cmd.start = 1'b1;
                     state_in  = ST_SCAN;
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            if (status.scan_done) begin
               state_in = ST_DRAIN;
            end else begin
               cmd.issue = 1'b1;
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // Wait until the result register is free.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Result valid flag follows the result register.
   assign rsp_valid_in = cmd.publish || (rsp_valid_ff && !rsp_ready);

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/pic_datapath.sv =====
// Point store, distance pipeline and hit counter.
module pic_datapath
   import pic_pkg::*;
#(
   parameter int POINT_CAPACITY = POINT_CAPACITY_DEF,
   parameter int COORD_BITS     = COORD_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [COORD_BITS-1:0] req_pos_x,
   input  logic [COORD_BITS-1:0] req_pos_y,
   input  logic [COORD_BITS-1:0] req_radius,
   output logic [COUNT_BITS-1:0] rsp_inside_count,
   output logic                  rsp_points_dropped,
   input  cmd_type               cmd,
   output status_type            status
);

   localparam int CNT_W = $clog2(POINT_CAPACITY + 1);
   localparam int IDX_W = (POINT_CAPACITY > 1) ? $clog2(POINT_CAPACITY) : 1;
   localparam int SQ_W  = 2 * COORD_BITS;

   // Point store: x in the upper half, y in the lower half.
   logic [SQ_W-1:0] store [POINT_CAPACITY];

   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  overflow_ff, overflow_in;
   logic [CNT_W-1:0]      idx_ff, idx_in;
   logic [COORD_BITS-1:0] cx_ff, cy_ff, radius_ff;
   logic [SQ_W-1:0]       r2_ff;
   logic                  full;

   // Pipeline registers.
   logic                  v1_ff, v2_ff, v3_ff;
   logic [SQ_W-1:0]       rd_data_ff;
   logic [COORD_BITS-1:0] dx_ff, dy_ff, dx_in, dy_in;
   logic [SQ_W-1:0]       sqx_ff, sqy_ff;
   logic [SQ_W:0]         dist2;
   logic [CNT_W-1:0]      hits_ff, hits_in;
   logic [COUNT_BITS-1:0] inside_count_ff;
   logic                  points_dropped_ff;

   assign full = (count_ff == CNT_W'(POINT_CAPACITY));

   // Fill count and sticky overflow flag.
   always_comb begin
      count_in    = count_ff;
      overflow_in = overflow_ff;
      if (cmd.clear) begin
         count_in    = '0;
         overflow_in = 1'b0;
      end else if (cmd.add) begin
         if (full) begin
            overflow_in = 1'b1;
         end else begin
            count_in = CNT_W'(count_ff + 1'b1);
         end
      end
   end

   // Scan index.
   always_comb begin
      idx_in = idx_ff;
      if (cmd.start) begin
         idx_in = '0;
      end else if (cmd.issue) begin
         idx_in = CNT_W'(idx_ff + 1'b1);
      end
   end

   assign status.scan_done = (idx_ff == count_ff);
   assign status.pipe_busy = v1_ff || v2_ff || v3_ff;

   // Store write and registered read.
   always_ff @(posedge clock) begin
      if (cmd.add && !full) begin
         store[count_ff[IDX_W-1:0]] <= {req_pos_x, req_pos_y};
      end
      if (cmd.issue) begin
         rd_data_ff <= store[idx_ff[IDX_W-1:0]];
      end
   end

   // Absolute coordinate differences.
   always_comb begin
      logic [COORD_BITS-1:0] px, py;
      px    = rd_data_ff[SQ_W-1:COORD_BITS];
      py    = rd_data_ff[COORD_BITS-1:0];
      dx_in = (px >= cx_ff) ? (px - cx_ff) : (cx_ff - px);
      dy_in = (py >= cy_ff) ? (py - cy_ff) : (cy_ff - py);
   end

   assign dist2 = {1'b0, sqx_ff} + {1'b0, sqy_ff};

   // Hit counter.
   always_comb begin
      hits_in = hits_ff;
      if (cmd.start) begin
         hits_in = '0;
      end else if (v3_ff && (dist2 <= {1'b0, r2_ff})) begin
         hits_in = CNT_W'(hits_ff + 1'b1);
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         overflow_ff <= 1'b0;
         idx_ff      <= '0;
         v1_ff       <= 1'b0;
         v2_ff       <= 1'b0;
         v3_ff       <= 1'b0;
         hits_ff     <= '0;
      end else begin
         count_ff    <= count_in;
         overflow_ff <= overflow_in;
         idx_ff      <= idx_in;
         v1_ff       <= cmd.issue;
         v2_ff       <= v1_ff;
         v3_ff       <= v2_ff;
         hits_ff     <= hits_in;
      end
   end

   // Query operands, radius square and pipeline payload.
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         cx_ff     <= req_pos_x;
         cy_ff     <= req_pos_y;
         radius_ff <= req_radius;
      end
      r2_ff  <= radius_ff * radius_ff;
      dx_ff  <= dx_in;
      dy_ff  <= dy_in;
      sqx_ff <= dx_ff * dx_ff;
      sqy_ff <= dy_ff * dy_ff;
      if (cmd.publish) begin
         inside_count_ff   <= COUNT_BITS'(hits_ff);
         points_dropped_ff <= overflow_ff;
      end
   end

   assign rsp_inside_count   = inside_count_ff;
   assign rsp_points_dropped = points_dropped_ff;

endmodule

// ===== rtl/points_in_circle_counter_unit.sv =====
// Top level of the points-in-circle counter: controller and datapath.
//
// The unit keeps up to POINT_CAPACITY points in an internal memory. A clear word
// empties the store and an add word appends a point; each gives no result, and an
// add to a full store is dropped and raises the sticky dropped flag.
// A query word scans the stored points through the single read port of the memory,
// one point per cycle, and a three-stage distance pipeline follows; the unit takes
// no new word until the query has drained and its result has been published.
// The result sits in an output register, so clear and add words are taken while it
// waits to be collected.
module points_in_circle_counter_unit
   import pic_pkg::*;
#(
   parameter int POINT_CAPACITY = POINT_CAPACITY_DEF,
   parameter int COORD_BITS     = COORD_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_op,
   input  logic [COORD_BITS-1:0] req_pos_x,
   input  logic [COORD_BITS-1:0] req_pos_y,
   input  logic [COORD_BITS-1:0] req_radius,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [COUNT_BITS-1:0] rsp_inside_count,
   output logic                  rsp_points_dropped
);

   cmd_type    cmd;
   status_type status;

   // Sequencer.
   pic_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (req_op),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   // Store and arithmetic.
   pic_datapath #(
      .POINT_CAPACITY (POINT_CAPACITY),
      .COORD_BITS     (COORD_BITS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_pos_x          (req_pos_x),
      .req_pos_y          (req_pos_y),
      .req_radius         (req_radius),
      .rsp_inside_count   (rsp_inside_count),
      .rsp_points_dropped (rsp_points_dropped),
      .cmd                (cmd),
      .status             (status)
   );

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the points-in-circle counter unit.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import pic_pkg::*;

   localparam int CBITS       = COORD_BITS_DEF;
   localparam int CMAX        = (1 << CBITS) - 1;
   localparam int CYCLE_LIMIT = 1_000_000;

   typedef struct {
      logic [COUNT_BITS-1:0] inside_count;
      logic                  points_dropped;
   } circle_answer_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic [1:0]       req_op = OP_CLEAR;
   logic [CBITS-1:0] req_pos_x = '0;
   logic [CBITS-1:0] req_pos_y = '0;
   logic [CBITS-1:0] req_radius = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic [COUNT_BITS-1:0] rsp_inside_count;
   logic             rsp_points_dropped;

   // Mirror of the point store, held at the block's widths.
   logic [CBITS-1:0] stored_x [POINT_CAPACITY_DEF];
   logic [CBITS-1:0] stored_y [POINT_CAPACITY_DEF];
   int               stored_count = 0;
   logic             drop_seen = 1'b0;
   circle_answer_type expected_answers[$];

   int error_count   = 0;
   int cycle_count   = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_request  = 0;
   int hold_left     = 0;

   points_in_circle_counter_unit uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_op             (req_op),
      .req_pos_x          (req_pos_x),
      .req_pos_y          (req_pos_y),
      .req_radius         (req_radius),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_inside_count   (rsp_inside_count),
      .rsp_points_dropped (rsp_points_dropped)
   );

   // Clock with a 12 ns period.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Run limit: a hang ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: run limit reached, %0d answers outstanding", $time,
                  expected_answers.size());
         $display("status: fail");
         $finish;
      end
   end

   // Count the stored points whose squared distance to the centre is within r squared.
   function automatic logic [COUNT_BITS-1:0] count_points_in_circle(int cx, int cy, int r);
      int hits;
      int dx;
      int dy;
      hits = 0;
      for (int i = 0; i < stored_count; i++) begin
         dx = int'(stored_x[i]) - cx;
         dy = int'(stored_y[i]) - cy;
         if (dx * dx + dy * dy <= r * r)
            hits++;
      end
      return hits[COUNT_BITS-1:0];
   endfunction

   // Apply one accepted word to the mirrored state and queue any answer it causes.
   function automatic void track_word(op_type op, logic [CBITS-1:0] x, logic [CBITS-1:0] y,
                                      logic [CBITS-1:0] r);
      circle_answer_type answer;
      case (op)
         OP_CLEAR: begin
            stored_count = 0;
            drop_seen    = 1'b0;
         end
         OP_ADD: begin
            if (stored_count < POINT_CAPACITY_DEF) begin
               stored_x[stored_count] = x;
               stored_y[stored_count] = y;
               stored_count++;
            end else begin
               drop_seen = 1'b1;
            end
         end
         OP_QUERY: begin
            answer.inside_count   = count_points_in_circle(x, y, r);
            answer.points_dropped = drop_seen;
            expected_answers.insert(expected_answers.size(), answer);
         end
         default: ;
      endcase
   endfunction

   // Both handshakes are observed at the rising edge, before the block updates.
   always @(posedge clock) begin
      circle_answer_type want;
      if (!reset) begin
         if (rsp_valid === 1'b1 && rsp_ready) begin
            if (expected_answers.size() == 0) begin
               $display("%0t: unexpected answer, expected none, got count %0d dropped %0b",
                        $time, rsp_inside_count, rsp_points_dropped);
               error_count++;
            end else begin
               want = expected_answers.pop_front();
               if (rsp_inside_count !== want.inside_count) begin
                  $display("%0t: inside_count mismatch, expected %0d, got %0d", $time,
                           want.inside_count, rsp_inside_count);
                  error_count++;
               end
               if (rsp_points_dropped !== want.points_dropped) begin
                  $display("%0t: points_dropped mismatch, expected %0b, got %0b", $time,
                           want.points_dropped, rsp_points_dropped);
                  error_count++;
               end
            end
         end
         if (req_valid && req_ready === 1'b1)
            track_word(op_type'(req_op), req_pos_x, req_pos_y, req_radius);
      end
   end

   // Result receiver: random stalls, or a long hold-off when one is requested.
   always @(negedge clock) begin
      if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         rsp_ready = 1'b0;
         hold_left--;
      end else begin
         rsp_ready = ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Offer one word, with random idle cycles first, and wait until it is taken.
   task automatic send_word(op_type op, int x, int y, int r);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid  = 1'b1;
      req_op     = op;
      req_pos_x  = x[CBITS-1:0];
      req_pos_y  = y[CBITS-1:0];
      req_radius = r[CBITS-1:0];
      do
         @(posedge clock);
      while (req_ready !== 1'b1);
   endtask

   // Stop offering words until every outstanding answer has been collected.
   task automatic wait_for_answers();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_answers.size() != 0)
         @(posedge clock);
   endtask

   function automatic int near_coord(int base, int spread);
      int v;
      v = base + int'($urandom_range(2 * spread)) - spread;
      return (v < 0) ? 0 : (v > CMAX) ? CMAX : v;
   endfunction

   // Queries on an empty store and an ignored operation code.
   task automatic test_empty_store();
      send_word(OP_QUERY, 0, 0, CMAX);
      send_word(OP_NONE, CMAX, CMAX, CMAX);
      send_word(OP_QUERY, CMAX, CMAX, 0);
   endtask

   // Boundary points, duplicates and coordinate extremes.
   task automatic test_boundary();
      send_word(OP_CLEAR, 0, 0, 0);
      send_word(OP_ADD, 10, 10, CMAX);
      send_word(OP_ADD, 13, 14, 0);
      send_word(OP_ADD, 10, 10, 0);
      send_word(OP_ADD, 0, 0, 0);
      send_word(OP_ADD, CMAX, CMAX, 0);
      send_word(OP_ADD, CMAX, 0, 0);
      send_word(OP_ADD, 0, CMAX, 0);
      send_word(OP_QUERY, 10, 10, 5);
      send_word(OP_QUERY, 10, 10, 4);
      send_word(OP_QUERY, 10, 10, 0);
      send_word(OP_NONE, 10, 10, 5);
      send_word(OP_QUERY, 0, 0, CMAX);
      send_word(OP_QUERY, CMAX, CMAX, 0);
      send_word(OP_QUERY, 0, 0, 0);
      send_word(OP_QUERY, 512, 512, 724);
      send_word(OP_QUERY, CMAX, CMAX, CMAX);
   endtask

   // Fill the store, overflow it, then check the sticky flag is cleared.
   task automatic test_overflow();
      send_word(OP_CLEAR, CMAX, CMAX, CMAX);
      for (int i = 0; i < POINT_CAPACITY_DEF; i++)
         send_word(OP_ADD, $urandom_range(CMAX), $urandom_range(CMAX), $urandom_range(CMAX));
      send_word(OP_QUERY, 512, 512, CMAX);
      send_word(OP_ADD, 512, 512, 0);
      send_word(OP_ADD, 0, 0, 0);
      send_word(OP_QUERY, 512, 512, CMAX);
      send_word(OP_QUERY, 0, 0, 0);
      send_word(OP_NONE, 0, 0, 0);
      send_word(OP_CLEAR, 0, 0, 0);
      send_word(OP_QUERY, 512, 512, CMAX);
      send_word(OP_ADD, 7, 9, 0);
      send_word(OP_QUERY, 7, 9, 0);
   endtask

   // Hold the receiver off while queries keep coming, then pause until drained.
   task automatic test_back_pressure();
      int bx;
      int by;
      bx = $urandom_range(CMAX);
      by = $urandom_range(CMAX);
      send_word(OP_CLEAR, 0, 0, 0);
      for (int i = 0; i < 24; i++)
         send_word(OP_ADD, near_coord(bx, 30), near_coord(by, 30), 0);
      hold_request = 500;
      for (int i = 0; i < 20; i++) begin
         send_word(OP_QUERY, near_coord(bx, 20), near_coord(by, 20), $urandom_range(40));
         if (i % 4 == 0)
            send_word(OP_ADD, near_coord(bx, 30), near_coord(by, 30), $urandom_range(CMAX));
      end
      wait_for_answers();
   endtask

   // Random sequences: mostly clear, adds around a cluster and queries, plus noise words.
   task automatic test_random(int word_budget);
      int sent;
      int bx;
      int by;
      int spread;
      int adds;
      int queries;
      int pick;
      int k;
      int cx;
      int cy;
      int r;
      sent = 0;
      while (sent < word_budget) begin
         if ($urandom_range(99) < 15) begin
            // Noise: any code with any fields.
            pick = $urandom_range(3);
            send_word(op_type'(pick), $urandom_range(CMAX), $urandom_range(CMAX),
                      $urandom_range(CMAX));
            if (pick != OP_NONE)
               sent++;
         end else begin
            bx     = $urandom_range(CMAX);
            by     = $urandom_range(CMAX);
            spread = ($urandom_range(3) == 0) ? CMAX : $urandom_range(1, 60);
            adds   = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(16);
            if ($urandom_range(3) != 0) begin
               send_word(OP_CLEAR, $urandom_range(CMAX), $urandom_range(CMAX),
                         $urandom_range(CMAX));
               sent++;
            end
            for (int i = 0; i < adds; i++) begin
               send_word(OP_ADD, near_coord(bx, spread), near_coord(by, spread),
                         $urandom_range(CMAX));
               sent++;
            end
            queries = $urandom_range(1, 4);
            for (int i = 0; i < queries; i++) begin
               pick = $urandom_range(3);
               cx   = near_coord(bx, spread);
               cy   = near_coord(by, spread);
               r    = $urandom_range(50);
               if (pick == 0) begin
                  cx = $urandom_range(CMAX);
                  cy = $urandom_range(CMAX);
                  r  = $urandom_range(CMAX);
               end else if (pick == 1 && stored_count > 0) begin
                  // Centre on a 3-4-5 offset from a stored point so it lies on the circle.
                  k  = $urandom_range(stored_count - 1);
                  cx = stored_x[k];
                  cy = stored_y[k];
                  r  = $urandom_range(1, 10);
                  cx = (cx >= 3 * r) ? cx - 3 * r : cx + 3 * r;
                  cy = (cy >= 4 * r) ? cy - 4 * r : cy + 4 * r;
                  r  = 5 * r;
               end
               send_word(OP_QUERY, cx, cy, r);
               sent++;
            end
         end
      end
   endtask

   task automatic set_idling(int send_pct, int recv_pct);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
   endtask

   // Test sequence.
   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      set_idling(0, 0);
      test_empty_store();
      test_boundary();
      set_idling(21, 21);
      test_overflow();
      set_idling(0, 0);
      test_back_pressure();
      test_random(25);
      set_idling(66, 0);
      test_random(25);
      set_idling(0, 66);
      test_random(25);
      set_idling(21, 21);
      test_random(25);

      wait_for_answers();
      repeat (POINT_CAPACITY_DEF + 16) @(posedge clock);
      if (error_count == 0 && expected_answers.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
